@@ hw/rtl/rpd_pkg.sv @@
// Shared types and constants for the pulse decoder with failsafe.
// No dependencies; every other file refers to it by scoped names.
package rpd_pkg;

  localparam int PULSE_COUNT_BITS = 12;
  localparam int TIMEOUT_BITS     = 20;
  localparam int DEADBAND_BITS    = 9;
  localparam int CFG_IDX_BITS     = 2;
  localparam int SPEED_BITS       = 9;
  localparam int DUTY_BITS        = 8;
  localparam int ANGLE_BITS       = 8;
  localparam int DIV_N_BITS       = 18;
  localparam int DIV_D_BITS       = 10;
  localparam int DIV_CNT_BITS     = 5;
  localparam int T_MAG_BITS       = 10;
  localparam int S_MAG_BITS       = 11;
  localparam int ANG_X_BITS       = 15;
  localparam int ANG_PROD_BITS    = 28;
  localparam int ANG_SHIFT        = 18;
  localparam int ANG_Q_BITS       = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT  = 2'd1;

  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RST = 9'd50;
  localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RST  = 20'd500000;

  // Pulse width limits and map anchor points, in microseconds
  localparam logic [PULSE_COUNT_BITS-1:0] W_LO   = PULSE_COUNT_BITS'(900);
  localparam logic [PULSE_COUNT_BITS-1:0] W_HI   = PULSE_COUNT_BITS'(2100);
  localparam logic [PULSE_COUNT_BITS-1:0] W_BASE = PULSE_COUNT_BITS'(1000);
  localparam logic [PULSE_COUNT_BITS-1:0] W_MID  = PULSE_COUNT_BITS'(1500);

  localparam logic [DEADBAND_BITS-1:0] HALF_SPAN   = 9'd500;
  localparam logic [DIV_D_BITS-1:0]    HALF_SPAN_D = 10'd500;
  localparam logic [DIV_D_BITS-1:0]    ANGLE_DEN   = 10'd1000;

  // ceil(2^18 / 50): angle = floor(9x / 50) via multiply and shift
  localparam logic [ANG_PROD_BITS-1:0] ANGLE_RECIP = 28'd5243;

  localparam logic signed [SPEED_BITS-1:0] SPEED_MAX  = 9'sd255;
  localparam logic signed [SPEED_BITS-1:0] SPEED_MIN  = -9'sd255;
  localparam logic signed [SPEED_BITS-1:0] SPEED_ZERO = 9'sd0;
  localparam logic [SPEED_BITS-1:0]        SPEED_OFS  = 9'd255;
  localparam logic [DIV_N_BITS-1:0]        Q_SPEED_HI = 18'd255;
  localparam logic [DIV_N_BITS-1:0]        Q_SPEED_LO = 18'd510;
  localparam logic [ANG_Q_BITS-1:0]        Q_ANGLE_HI = 10'd180;

  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX    = 8'd180;
  localparam logic [ANGLE_BITS-1:0] ANGLE_ZERO   = 8'd0;
  localparam logic [ANGLE_BITS-1:0] ANGLE_CENTER = 8'd90;

  typedef struct packed {
    logic                        done;
    logic                        lost;
    logic [PULSE_COUNT_BITS-1:0] width;
  } chan_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T_SETUP,
    ST_T_WAIT,
    ST_S_SETUP,
    ST_S_WAIT,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/rpd_if.sv @@
// Handshake channels for the pulse decoder: tick input, result output, register writes.
// Depends on rpd_pkg for field widths.
interface rpd_in_if;
  logic valid;
  logic ready;
  logic throttle_level;
  logic steering_level;
  modport source (output valid, throttle_level, steering_level, input ready);
  modport sink   (input valid, throttle_level, steering_level, output ready);
endinterface

interface rpd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rpd_pkg::SPEED_BITS-1:0] motor_speed;
  logic                                  drive_forward;
  logic                                  drive_reverse;
  logic [rpd_pkg::DUTY_BITS-1:0]         duty;
  logic [rpd_pkg::ANGLE_BITS-1:0]        servo_angle;
  logic                                  throttle_lost;
  logic                                  steering_lost;
  modport source (output valid, motor_speed, drive_forward, drive_reverse, duty,
                  servo_angle, throttle_lost, steering_lost, input ready);
  modport sink   (input valid, motor_speed, drive_forward, drive_reverse, duty,
                  servo_angle, throttle_lost, steering_lost, output ready);
endinterface

interface rpd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rpd_pkg::CFG_IDX_BITS-1:0]    index;
  logic [rpd_pkg::TIMEOUT_BITS-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/rc_pulse_decoder_with_failsafe_unit.sv @@
// Top level of the pulse decoder: two channel trackers, a throttle-map divider, the map sequencer.
// Depends on rpd_pkg, rpd_if, rpd_chan and rpd_div.
//
//  channel  dir  beat carries                                   flow
//  in_ch    in   throttle_level, steering_level (one us tick)   valid/ready
//  out_ch   out  motor_speed, drive_*, duty, angle, lost flags  valid/ready
//  cfg_ch   in   index, data (deadband_us, timeout_us)          valid/ready, always ready
//
// A tick with no completed pulse walks IDLE, T_SETUP, S_SETUP and FINISH between accepts.
// A throttle pulse that reaches the divided map adds T_WAIT on the 18-step divider;
// a steering pulse in range at or above 1000 us adds S_WAIT for its reciprocal multiply.
// in_ch is ready only in IDLE, so the next tick waits until the sequencer is back there.
// Reset (rst_n low, synchronous) clears channels, speed 0, angle 90, registers to defaults.
// A stalled output holds its beat; the sequencer waits in its last state until it drains.
module rc_pulse_decoder_with_failsafe_unit (
  input  logic      clk,
  input  logic      rst_n,
  rpd_in_if.sink    in_ch,
  rpd_out_if.source out_ch,
  rpd_cfg_if.sink   cfg_ch
);

  localparam int PCB = rpd_pkg::PULSE_COUNT_BITS;

  rpd_pkg::state_t state_r, state_nxt;

  logic [rpd_pkg::DEADBAND_BITS-1:0] deadband_r, deadband_nxt;
  logic [rpd_pkg::TIMEOUT_BITS-1:0]  timeout_r, timeout_nxt;

  rpd_pkg::chan_stat_t t_stat, s_stat;
  logic                in_acc;

  logic            t_ok_r, s_ok_r, t_lost_r, s_lost_r;
  logic [PCB-1:0]  tw_r, sw_r;

  logic signed [rpd_pkg::SPEED_BITS-1:0] speed_r;
  logic [rpd_pkg::ANGLE_BITS-1:0]        angle_r;

  // throttle map datapath
  logic [PCB-1:0]                      band_lo, band_hi, t_diff;
  logic                                in_band, below_mid, below_base, span_ok;
  logic [rpd_pkg::T_MAG_BITS-1:0]      t_mag;
  logic [rpd_pkg::DIV_N_BITS-1:0]      t_ext, t_num;
  logic [rpd_pkg::DIV_D_BITS-1:0]      t_span;
  logic signed [rpd_pkg::SPEED_BITS-1:0] t_full, t_div_speed;

  // steering map datapath
  logic                                s_neg;
  logic [rpd_pkg::S_MAG_BITS-1:0]      s_mag;
  logic [rpd_pkg::ANG_X_BITS-1:0]      s_ext, s_x9;
  logic [rpd_pkg::ANG_PROD_BITS-1:0]   s_prod;
  logic [rpd_pkg::ANG_Q_BITS-1:0]      s_q_r;
  logic [rpd_pkg::ANGLE_BITS-1:0]      s_div_angle;

  // divider, used by the throttle map only
  logic                                div_start, div_done;
  logic [rpd_pkg::DIV_N_BITS-1:0]      div_num, div_quot;
  logic [rpd_pkg::DIV_D_BITS-1:0]      div_den;

  // sequencer outputs
  logic                                  spd_we, ang_we, out_load;
  logic signed [rpd_pkg::SPEED_BITS-1:0] spd_val;
  logic [rpd_pkg::ANGLE_BITS-1:0]        ang_val;

  // output stage
  logic                                  out_valid_r;
  logic signed [rpd_pkg::SPEED_BITS-1:0] o_speed_r;
  logic                                  o_fwd_r, o_rev_r, o_tlost_r, o_slost_r;
  logic [rpd_pkg::DUTY_BITS-1:0]         o_duty_r;
  logic [rpd_pkg::ANGLE_BITS-1:0]        o_angle_r;
  logic [rpd_pkg::SPEED_BITS-1:0]        speed_mag;

  assign in_ch.ready  = (state_r == rpd_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // ---------------- configuration registers ----------------
  always_comb begin
    deadband_nxt = deadband_r;
    timeout_nxt  = timeout_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rpd_pkg::REG_DEADBAND: deadband_nxt = cfg_ch.data[rpd_pkg::DEADBAND_BITS-1:0];
        rpd_pkg::REG_TIMEOUT:  timeout_nxt  = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= rpd_pkg::DEADBAND_RST;
      timeout_r  <= rpd_pkg::TIMEOUT_RST;
    end else begin
      deadband_r <= deadband_nxt;
      timeout_r  <= timeout_nxt;
    end
  end

  // ---------------- channels ----------------
  rpd_chan u_thr (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .level   (in_ch.throttle_level),
    .timeout (timeout_r),
    .stat    (t_stat)
  );

  rpd_chan u_str (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .level   (in_ch.steering_level),
    .timeout (timeout_r),
    .stat    (s_stat)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_ok_r   <= t_stat.done && t_stat.width >= rpd_pkg::W_LO && t_stat.width <= rpd_pkg::W_HI;
      s_ok_r   <= s_stat.done && s_stat.width >= rpd_pkg::W_LO && s_stat.width <= rpd_pkg::W_HI;
      t_lost_r <= t_stat.lost;
      s_lost_r <= s_stat.lost;
      tw_r     <= t_stat.width;
      sw_r     <= s_stat.width;
    end
  end

  // ---------------- map datapath ----------------
  always_comb begin
    band_lo    = rpd_pkg::W_MID - PCB'(deadband_r);
    band_hi    = rpd_pkg::W_MID + PCB'(deadband_r);
    in_band    = (tw_r > band_lo) && (tw_r < band_hi);
    below_mid  = tw_r < rpd_pkg::W_MID;
    below_base = tw_r < rpd_pkg::W_BASE;
    span_ok    = deadband_r < rpd_pkg::HALF_SPAN;
    t_span     = rpd_pkg::HALF_SPAN_D - rpd_pkg::DIV_D_BITS'(deadband_r);
    t_full     = below_mid ? rpd_pkg::SPEED_MIN : rpd_pkg::SPEED_MAX;
    if (below_mid) begin
      t_diff = below_base ? (rpd_pkg::W_BASE - tw_r) : (tw_r - rpd_pkg::W_BASE);
    end else begin
      t_diff = tw_r - band_hi;
    end
    t_mag = t_diff[rpd_pkg::T_MAG_BITS-1:0];
    t_ext = rpd_pkg::DIV_N_BITS'(t_mag);
    t_num = (t_ext << 8) - t_ext;  // x255

    // Lower half: q - 255 (full forward above 510), or full reverse below 1000 us; upper half: q capped at 255.
    if (below_mid) begin
      if (below_base) begin
        t_div_speed = rpd_pkg::SPEED_MIN;
      end else if (div_quot > rpd_pkg::Q_SPEED_LO) begin
        t_div_speed = rpd_pkg::SPEED_MAX;
      end else begin
        t_div_speed = $signed(div_quot[rpd_pkg::SPEED_BITS-1:0] - rpd_pkg::SPEED_OFS);
      end
    end else if (div_quot > rpd_pkg::Q_SPEED_HI) begin
      t_div_speed = rpd_pkg::SPEED_MAX;
    end else begin
      t_div_speed = $signed(div_quot[rpd_pkg::SPEED_BITS-1:0]);
    end

    // x * 180 / 1000 == 9x / 50; the reciprocal is exact for 9x up to 9900
    s_neg  = sw_r < rpd_pkg::W_BASE;
    s_mag  = rpd_pkg::S_MAG_BITS'(sw_r - rpd_pkg::W_BASE);
    s_ext  = rpd_pkg::ANG_X_BITS'(s_mag);
    s_x9   = (s_ext << 3) + s_ext;
    s_prod = rpd_pkg::ANG_PROD_BITS'(s_x9) * rpd_pkg::ANGLE_RECIP;
    s_div_angle = (s_q_r > rpd_pkg::Q_ANGLE_HI) ? rpd_pkg::ANGLE_MAX
                                                : s_q_r[rpd_pkg::ANGLE_BITS-1:0];

    div_num = t_num;
    div_den = t_span;
  end

  always_ff @(posedge clk) begin
    if (state_r == rpd_pkg::ST_S_SETUP) begin
      s_q_r <= s_prod[rpd_pkg::ANG_SHIFT +: rpd_pkg::ANG_Q_BITS];
    end
  end

  rpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpd_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = rpd_pkg::ST_T_SETUP;
      end
      rpd_pkg::ST_T_SETUP: begin
        if (t_lost_r || !t_ok_r || in_band || !span_ok) begin
          state_nxt = rpd_pkg::ST_S_SETUP;
        end else begin
          state_nxt = rpd_pkg::ST_T_WAIT;
        end
      end
      rpd_pkg::ST_T_WAIT: begin
        if (div_done) state_nxt = rpd_pkg::ST_S_SETUP;
      end
      rpd_pkg::ST_S_SETUP: begin
        if (!s_lost_r && s_ok_r && !s_neg) begin
          state_nxt = rpd_pkg::ST_S_WAIT;
        end else begin
          state_nxt = rpd_pkg::ST_FINISH;
        end
      end
      rpd_pkg::ST_S_WAIT: begin
        state_nxt = rpd_pkg::ST_FINISH;
      end
      rpd_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) state_nxt = rpd_pkg::ST_IDLE;
      end
      default: state_nxt = rpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start     = 1'b0;
    spd_we        = 1'b0;
    spd_val       = rpd_pkg::SPEED_ZERO;
    ang_we        = 1'b0;
    ang_val       = rpd_pkg::ANGLE_ZERO;
    out_load      = 1'b0;
    unique case (state_r)
      rpd_pkg::ST_IDLE: ;
      rpd_pkg::ST_T_SETUP: begin
        if (t_lost_r) begin
          spd_we = 1'b1;
        end else if (t_ok_r) begin
          if (in_band) begin
            spd_we = 1'b1;
          end else if (!span_ok) begin
            spd_we  = 1'b1;
            spd_val = t_full;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      rpd_pkg::ST_T_WAIT: begin
        spd_we  = div_done;
        spd_val = t_div_speed;
      end
      rpd_pkg::ST_S_SETUP: begin
        // below 1000 us the angle clamps to zero
        if (!s_lost_r && s_ok_r && s_neg) begin
          ang_we = 1'b1;
        end
      end
      rpd_pkg::ST_S_WAIT: begin
        ang_we  = 1'b1;
        ang_val = s_div_angle;
      end
      rpd_pkg::ST_FINISH: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpd_pkg::ST_IDLE;
      speed_r <= rpd_pkg::SPEED_ZERO;
      angle_r <= rpd_pkg::ANGLE_CENTER;
    end else begin
      state_r <= state_nxt;
      if (spd_we) speed_r <= spd_val;
      if (ang_we) angle_r <= ang_val;
    end
  end

  // ---------------- output register ----------------
  assign speed_mag = speed_r[rpd_pkg::SPEED_BITS-1] ? -speed_r : speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_speed_r <= speed_r;
      o_fwd_r   <= (speed_r > rpd_pkg::SPEED_ZERO);
      o_rev_r   <= speed_r[rpd_pkg::SPEED_BITS-1];
      o_duty_r  <= speed_mag[rpd_pkg::DUTY_BITS-1:0];
      o_angle_r <= angle_r;
      o_tlost_r <= t_lost_r;
      o_slost_r <= s_lost_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_speed   = o_speed_r;
  assign out_ch.drive_forward = o_fwd_r;
  assign out_ch.drive_reverse = o_rev_r;
  assign out_ch.duty          = o_duty_r;
  assign out_ch.servo_angle   = o_angle_r;
  assign out_ch.throttle_lost = o_tlost_r;
  assign out_ch.steering_lost = o_slost_r;

endmodule

@@ hw/rtl/rpd_chan.sv @@
// One pulse channel: edge detect, saturating high-time count, elapsed-time counter.
// Depends on rpd_pkg.
module rpd_chan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic                               level,
  input  logic [rpd_pkg::TIMEOUT_BITS-1:0]   timeout,
  output rpd_pkg::chan_stat_t                stat
);

  logic                                  prev_r, prev_nxt;
  logic                                  seen_r, seen_nxt;
  logic [rpd_pkg::PULSE_COUNT_BITS-1:0]  hc_r, hc_nxt;
  logic [rpd_pkg::TIMEOUT_BITS-1:0]      el_r, el_nxt;
  logic                                  rise;
  logic                                  fall;

  always_comb begin
    rise     = level & ~prev_r;
    fall     = ~level & prev_r & seen_r;
    prev_nxt = level;
    seen_nxt = seen_r | rise;
    hc_nxt   = hc_r;
    if (rise) begin
      hc_nxt = rpd_pkg::PULSE_COUNT_BITS'(1);
    end else if (level && seen_r && hc_r != '1) begin
      hc_nxt = hc_r + 1'b1;
    end
    el_nxt = el_r;
    if (fall) begin
      el_nxt = '0;
    end else if (el_r != '1) begin
      el_nxt = el_r + 1'b1;
    end
  end

  // Status reflects this tick's update; width is the count before the fall.
  assign stat.done  = fall;
  assign stat.lost  = el_nxt > timeout;
  assign stat.width = hc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      seen_r <= 1'b0;
      hc_r   <= '0;
      el_r   <= '0;
    end else if (step) begin
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      hc_r   <= hc_nxt;
      el_r   <= el_nxt;
    end
  end

endmodule

@@ hw/rtl/rpd_div.sv @@
// Restoring divider for the throttle map, one quotient bit per cycle, unsigned operands.
// Depends on rpd_pkg for operand widths.
module rpd_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rpd_pkg::DIV_N_BITS-1:0]   num,
  input  logic [rpd_pkg::DIV_D_BITS-1:0]   den,
  output logic [rpd_pkg::DIV_N_BITS-1:0]   quot,
  output logic                             done
);

  logic [rpd_pkg::DIV_N_BITS-1:0]   quot_r;
  logic [rpd_pkg::DIV_D_BITS-1:0]   den_r;
  logic [rpd_pkg::DIV_D_BITS-1:0]   rem_r;
  logic [rpd_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [rpd_pkg::DIV_D_BITS:0]     trial;
  logic [rpd_pkg::DIV_D_BITS:0]     diff;
  logic                             ge;
  logic                             last;

  always_comb begin
    trial = {rem_r, quot_r[rpd_pkg::DIV_N_BITS-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
    last  = busy_r && (cnt_r == rpd_pkg::DIV_CNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      den_r  <= den;
      rem_r  <= '0;
      cnt_r  <= rpd_pkg::DIV_CNT_BITS'(rpd_pkg::DIV_N_BITS);
    end else if (busy_r) begin
      rem_r  <= ge ? diff[rpd_pkg::DIV_D_BITS-1:0] : trial[rpd_pkg::DIV_D_BITS-1:0];
      quot_r <= {quot_r[rpd_pkg::DIV_N_BITS-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

@@ hw/rtl/rpd_checker.sv @@
// Port-level checks on the pulse decoder's result channel, bound to the top level.
// Depends on rpd_pkg and rc_pulse_decoder_with_failsafe_unit.
module rpd_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [rpd_pkg::SPEED_BITS-1:0] motor_speed,
  input logic                                  drive_forward,
  input logic                                  drive_reverse,
  input logic [rpd_pkg::DUTY_BITS-1:0]         duty,
  input logic [rpd_pkg::ANGLE_BITS-1:0]        servo_angle,
  input logic                                  throttle_lost
);

  // stalled beat holds its speed and angle
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(motor_speed) && $stable(servo_angle))
    else $error("result beat changed while stalled");

  a_drive_legs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(drive_forward && drive_reverse)
                  && (drive_forward == (motor_speed > rpd_pkg::SPEED_ZERO))
                  && (drive_reverse == (motor_speed < rpd_pkg::SPEED_ZERO)))
    else $error("bridge legs disagree with speed sign");

  a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && motor_speed == rpd_pkg::SPEED_ZERO |-> duty == '0)
    else $error("nonzero duty at zero speed");

  a_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && throttle_lost |-> motor_speed == rpd_pkg::SPEED_ZERO)
    else $error("speed not forced to zero on throttle loss");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> servo_angle <= rpd_pkg::ANGLE_MAX)
    else $error("servo angle out of range");

endmodule

bind rc_pulse_decoder_with_failsafe_unit rpd_checker u_rpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .motor_speed   (out_ch.motor_speed),
  .drive_forward (out_ch.drive_forward),
  .drive_reverse (out_ch.drive_reverse),
  .duty          (out_ch.duty),
  .servo_angle   (out_ch.servo_angle),
  .throttle_lost (out_ch.throttle_lost)
);
